// ----- rtl/core/obsd_pkg.sv -----
// ----------------------------------------------------------------------------
// obsd_pkg
// Shared types and constants for the optical bit slicer and sync detector.
// ----------------------------------------------------------------------------
package obsd_pkg;

  localparam int FRAC_BITS         = 4;
  localparam int MAX_SYMBOL_FRAMES = 30;
  localparam int MIN_SYMBOL_FRAMES = 2;

  localparam int COLOR_W = 12;
  localparam int DIFF_W  = COLOR_W + 1;
  localparam int SIG_W   = 13;
  localparam int ACC_W   = 31;
  localparam int WGT_FRAC = 16;
  localparam int SUM_W   = 18;
  localparam int CNT_W   = 5;
  localparam int CALF_W  = 8;
  localparam int LVL2_W  = SIG_W + 1;
  localparam int CMP_W   = 20;
  localparam int HIST_W  = 14;
  localparam int FILL_W  = 4;
  localparam int IDX_W   = 2;
  localparam int ACT_W   = 2;

  // Q16 luma weights
  localparam logic signed [ACC_W-1:0] W_BLUE  = ACC_W'(7471);
  localparam logic signed [ACC_W-1:0] W_GREEN = ACC_W'(38470);
  localparam logic signed [ACC_W-1:0] W_RED   = ACC_W'(19595);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (WGT_FRAC - 1));

  // preamble 10101010 then start 111000, oldest bit first
  localparam logic [HIST_W-1:0] SYNC_PATTERN = 14'h2AB8;
  localparam logic [FILL_W-1:0] SYNC_LEN     = FILL_W'(HIST_W);

  localparam logic signed [SIG_W-1:0] SIG_MAX = 13'sd4095;
  localparam logic signed [SIG_W-1:0] SIG_MIN = -13'sd4096;

  localparam logic [CNT_W-1:0]  EFF_MIN = CNT_W'(MIN_SYMBOL_FRAMES);
  localparam logic [CNT_W-1:0]  EFF_MAX = CNT_W'(MAX_SYMBOL_FRAMES);
  localparam logic [CALF_W-1:0] CAL_CNT_MAX = '1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FRAMES_PER_SYMBOL  = 2'd0;
  localparam logic [IDX_W-1:0] REG_CALIBRATION_FRAMES = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEFAULT_THRESHOLD  = 2'd2;

  // register reset values
  localparam logic [CNT_W-1:0]        RST_FRAMES_PER_SYMBOL  = 5'd6;
  localparam logic [CALF_W-1:0]       RST_CALIBRATION_FRAMES = 8'd60;
  localparam logic signed [SIG_W-1:0] RST_DEFAULT_THRESHOLD  = SIG_W'(20 << FRAC_BITS);
  localparam logic signed [SIG_W-1:0] RST_WHITE_LEVEL        = SIG_W'(255 << FRAC_BITS);

  // action codes
  localparam logic [ACT_W-1:0] ACT_SAMPLE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BLACK     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_WHITE     = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CALIBRATE = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]        frames_per_symbol;
    logic [CALF_W-1:0]       calibration_frames;
    logic signed [SIG_W-1:0] default_threshold;
  } cfg_t;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [SIG_W-1:0] sig;
  } sample_t;

endpackage

// ----- rtl/core/obsd_if.sv -----
// ----------------------------------------------------------------------------
// obsd_if
// Valid/ready channels: frame samples in, slicer results out, register writes.
// ----------------------------------------------------------------------------
interface obsd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [11:0] center_blue;
  logic [11:0] center_green;
  logic [11:0] center_red;
  logic [11:0] ambient_blue;
  logic [11:0] ambient_green;
  logic [11:0] ambient_red;

  modport source (
    output valid, action, center_blue, center_green, center_red,
           ambient_blue, ambient_green, ambient_red,
    input  ready
  );
  modport sink (
    input  valid, action, center_blue, center_green, center_red,
           ambient_blue, ambient_green, ambient_red,
    output ready
  );
endinterface

interface obsd_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] frame_signal;
  logic               symbol_done;
  logic               sliced_bit;
  logic               bit_valid;
  logic               sync_locked;
  logic               calibrating;

  modport source (
    output valid, frame_signal, symbol_done, sliced_bit, bit_valid,
           sync_locked, calibrating,
    input  ready
  );
  modport sink (
    input  valid, frame_signal, symbol_done, sliced_bit, bit_valid,
           sync_locked, calibrating,
    output ready
  );
endinterface

interface obsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/obsd_cfg.sv -----
// ----------------------------------------------------------------------------
// obsd_cfg
// Configuration register file, written one beat at a time.
// ----------------------------------------------------------------------------
module obsd_cfg
  import obsd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  obsd_cfg_if.sink        cfg_if,
  output cfg_t            cfg
);

  logic [CNT_W-1:0]        fps_r;
  logic [CALF_W-1:0]       calf_r;
  logic signed [SIG_W-1:0] thr_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fps_r  <= RST_FRAMES_PER_SYMBOL;
      calf_r <= RST_CALIBRATION_FRAMES;
      thr_r  <= RST_DEFAULT_THRESHOLD;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_FRAMES_PER_SYMBOL:  fps_r  <= cfg_if.data[CNT_W-1:0];
        REG_CALIBRATION_FRAMES: calf_r <= cfg_if.data[CALF_W-1:0];
        REG_DEFAULT_THRESHOLD:  thr_r  <= $signed(cfg_if.data[SIG_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg.frames_per_symbol  = fps_r;
  assign cfg.calibration_frames = calf_r;
  assign cfg.default_threshold  = thr_r;

endmodule

// ----- rtl/core/obsd_luma.sv -----
// ----------------------------------------------------------------------------
// obsd_luma
// Centre minus ambient luma in sixteenths, rounded, registered per beat.
// ----------------------------------------------------------------------------
module obsd_luma
  import obsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  obsd_in_if.sink  in_if,
  input  logic     dn_ready,
  output logic     smp_valid,
  output sample_t  smp
);

  logic                    valid_r;
  sample_t                 smp_r;
  logic                    load;
  logic signed [DIFF_W-1:0] db, dg, dr;
  logic signed [ACC_W-1:0]  pb, pg, pr, acc;

  assign in_if.ready = !valid_r || dn_ready;
  assign load        = in_if.valid && in_if.ready;

  always_comb begin
    db  = $signed({1'b0, in_if.center_blue})  - $signed({1'b0, in_if.ambient_blue});
    dg  = $signed({1'b0, in_if.center_green}) - $signed({1'b0, in_if.ambient_green});
    dr  = $signed({1'b0, in_if.center_red})   - $signed({1'b0, in_if.ambient_red});
    pb  = ACC_W'(db) * W_BLUE;
    pg  = ACC_W'(dg) * W_GREEN;
    pr  = ACC_W'(dr) * W_RED;
    acc = pb + pg + pr + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      smp_r.action <= in_if.action;
      smp_r.sig    <= $signed(acc[WGT_FRAC+SIG_W-1:WGT_FRAC]);
    end
  end

  assign smp_valid = valid_r;
  assign smp       = smp_r;

endmodule

// ----- rtl/core/obsd_slicer.sv -----
// ----------------------------------------------------------------------------
// obsd_slicer
// Calibration, symbol integration, bit slicing and sync search; result register.
// ----------------------------------------------------------------------------
module obsd_slicer
  import obsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      smp_valid,
  input  sample_t   smp,
  output logic      smp_ready,
  obsd_out_if.source out_if
);

  // symbol and sync state
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [HIST_W-1:0]        hist_r, hist_nxt;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  logic                     locked_r, locked_nxt;
  // levels and calibration
  logic                     bk_r, bk_nxt, wk_r, wk_nxt;
  logic signed [SIG_W-1:0]  black_r, black_nxt, white_r, white_nxt;
  logic                     cal_r, cal_nxt;
  logic [CALF_W-1:0]        ccnt_r, ccnt_nxt;
  logic signed [SIG_W-1:0]  cmin_r, cmin_nxt, cmax_r, cmax_nxt;
  // result register
  logic                     ovalid_r;
  logic signed [SIG_W-1:0]  osig_r;
  logic                     odone_r, obit_r, obv_r, olock_r, ocal_r;

  logic                     adv;
  logic [CNT_W-1:0]         eff, cnt_inc;
  logic                     done, sbit, both;
  logic signed [LVL2_W-1:0] mult_a;
  logic signed [CMP_W-1:0]  lhs, rhs, a_ext, n_ext;

  assign smp_ready = !ovalid_r || out_if.ready;
  assign adv       = smp_valid && smp_ready;

  always_comb begin
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    hist_nxt   = hist_r;
    fill_nxt   = fill_r;
    locked_nxt = locked_r;
    bk_nxt     = bk_r;
    wk_nxt     = wk_r;
    black_nxt  = black_r;
    white_nxt  = white_r;
    cal_nxt    = cal_r;
    ccnt_nxt   = ccnt_r;
    cmin_nxt   = cmin_r;
    cmax_nxt   = cmax_r;

    priority if (cfg.frames_per_symbol < EFF_MIN) begin
      eff = EFF_MIN;
    end else if (cfg.frames_per_symbol > EFF_MAX) begin
      eff = EFF_MAX;
    end else begin
      eff = cfg.frames_per_symbol;
    end

    if (cal_r) begin
      if (smp.sig < cmin_r) cmin_nxt = smp.sig;
      if (smp.sig > cmax_r) cmax_nxt = smp.sig;
      if (ccnt_r != CAL_CNT_MAX) ccnt_nxt = ccnt_r + 1'b1;
      if (ccnt_nxt >= cfg.calibration_frames) begin
        cal_nxt   = 1'b0;
        black_nxt = cmin_nxt;
        white_nxt = cmax_nxt;
        bk_nxt    = 1'b1;
        wk_nxt    = 1'b1;
      end
    end

    // sum_r + sig stays within +-30 * 4095
    sum_nxt = sum_r + SUM_W'(smp.sig);
    cnt_inc = cnt_r + 1'b1;
    done    = cnt_inc >= eff;

    // sum > thr * n, or 2 * sum > (black + white) * n
    both   = bk_nxt && wk_nxt;
    mult_a = both ? (LVL2_W'(black_nxt) + LVL2_W'(white_nxt))
                  : LVL2_W'(cfg.default_threshold);
    lhs    = both ? (CMP_W'(sum_nxt) <<< 1) : CMP_W'(sum_nxt);
    a_ext  = CMP_W'(mult_a);
    n_ext  = $signed({{(CMP_W-CNT_W){1'b0}}, cnt_inc});
    rhs    = a_ext * n_ext;
    sbit   = !(lhs > rhs);

    if (done) begin
      sum_nxt  = '0;
      cnt_nxt  = '0;
      hist_nxt = {hist_r[HIST_W-2:0], sbit};
      if (fill_r < SYNC_LEN) fill_nxt = fill_r + 1'b1;
      if (fill_nxt == SYNC_LEN && hist_nxt == SYNC_PATTERN) locked_nxt = 1'b1;
    end else begin
      cnt_nxt = cnt_inc;
    end

    unique case (smp.action)
      ACT_BLACK: begin
        black_nxt = smp.sig;
        bk_nxt    = 1'b1;
      end
      ACT_WHITE: begin
        white_nxt = smp.sig;
        wk_nxt    = 1'b1;
      end
      ACT_CALIBRATE: begin
        cal_nxt  = 1'b1;
        ccnt_nxt = '0;
        cmin_nxt = SIG_MAX;
        cmax_nxt = SIG_MIN;
      end
      ACT_SAMPLE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      cnt_r    <= '0;
      hist_r   <= '0;
      fill_r   <= '0;
      locked_r <= 1'b0;
      bk_r     <= 1'b0;
      wk_r     <= 1'b0;
      black_r  <= '0;
      white_r  <= RST_WHITE_LEVEL;
      cal_r    <= 1'b0;
      ccnt_r   <= '0;
      cmin_r   <= SIG_MAX;
      cmax_r   <= SIG_MIN;
      ovalid_r <= 1'b0;
    end else begin
      if (adv) begin
        sum_r    <= sum_nxt;
        cnt_r    <= cnt_nxt;
        hist_r   <= hist_nxt;
        fill_r   <= fill_nxt;
        locked_r <= locked_nxt;
        bk_r     <= bk_nxt;
        wk_r     <= wk_nxt;
        black_r  <= black_nxt;
        white_r  <= white_nxt;
        cal_r    <= cal_nxt;
        ccnt_r   <= ccnt_nxt;
        cmin_r   <= cmin_nxt;
        cmax_r   <= cmax_nxt;
      end
      if (smp_ready) begin
        ovalid_r <= smp_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      osig_r  <= smp.sig;
      odone_r <= done;
      obit_r  <= done && sbit;
      obv_r   <= done && locked_nxt;
      olock_r <= locked_nxt;
      ocal_r  <= cal_nxt;
    end
  end

  assign out_if.valid        = ovalid_r;
  assign out_if.frame_signal = osig_r;
  assign out_if.symbol_done  = odone_r;
  assign out_if.sliced_bit   = obit_r;
  assign out_if.bit_valid    = obv_r;
  assign out_if.sync_locked  = olock_r;
  assign out_if.calibrating  = ocal_r;

`ifndef SYNTH
  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    locked_r |=> locked_r)
    else $error("sync lock dropped");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < EFF_MAX)
    else $error("frame counter past symbol length");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= SYNC_LEN)
    else $error("history fill past sync length");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && done) |=> (cnt_r == '0 && sum_r == '0))
    else $error("symbol state not cleared after decision");

  a_lock_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    locked_r |-> (fill_r == SYNC_LEN))
    else $error("locked before history full");
`endif

endmodule

// ----- rtl/core/optical_bit_slicer_sync_detect.sv -----
// ----------------------------------------------------------------------------
// optical_bit_slicer_sync_detect
// Optical link receiver front end: luma slicer with preamble sync detection.
// ----------------------------------------------------------------------------
// One beat on in_if per camera frame: action code plus mean centre and ambient
// colors (8.4). One beat on out_if per input beat, in order: the frame's luma
// difference, symbol decision, sliced bit, payload flag, sync and cal status.
// cfg_if writes frames_per_symbol (0), calibration_frames (1) and
// default_threshold (2); it is always ready. Write it only while idle.
// A result reaches out_if through the luma register, then the result register.
// Throughput: one beat per cycle while out_if is ready.
// Reset (rst_n low, synchronous) restores the register defaults, clears sum,
// history and lock, forgets the black/white levels and drops both valids.
// If out_if stalls, the result register holds and one more frame is taken into
// the luma register; in_if.ready falls only when both are full.
// ----------------------------------------------------------------------------
module optical_bit_slicer_sync_detect
  import obsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  obsd_in_if.sink     in_if,
  obsd_out_if.source  out_if,
  obsd_cfg_if.sink    cfg_if
);

  cfg_t    cfg;
  logic    smp_valid;
  logic    smp_ready;
  sample_t smp;

  obsd_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  obsd_luma u_luma (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .dn_ready  (smp_ready),
    .smp_valid (smp_valid),
    .smp       (smp)
  );

  obsd_slicer u_slicer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .smp_valid (smp_valid),
    .smp       (smp),
    .smp_ready (smp_ready),
    .out_if    (out_if)
  );

endmodule

// ----- dv/obsd_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obsd_checker
// Passive scoreboard for the optical bit slicer: follows register writes and
// frame beats, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
module obsd_checker
  import obsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  obsd_in_if   in_if,
  obsd_out_if  out_if,
  obsd_cfg_if  cfg_if,
  output int   fail_count,
  output int   pending,
  output int   symbols_seen,
  output int   payload_seen,
  output logic lock_seen
);

  localparam int EXP_DEPTH = 8;

  typedef struct packed {
    logic signed [SIG_W-1:0] frame_signal;
    logic                    symbol_done;
    logic                    sliced_bit;
    logic                    bit_valid;
    logic                    sync_locked;
    logic                    calibrating;
  } slice_result_t;

  slice_result_t exp_fifo [EXP_DEPTH];
  logic [2:0]    exp_wr;
  logic [2:0]    exp_rd;
  int            exp_count;
  slice_result_t want;

  cfg_t                    regs;
  logic signed [SUM_W-1:0] sym_sum;
  logic [CNT_W-1:0]        frame_cnt;
  logic [HIST_W-1:0]       hist;
  logic [FILL_W-1:0]       fill;
  logic                    black_ok;
  logic                    white_ok;
  logic signed [SIG_W-1:0] black_lvl;
  logic signed [SIG_W-1:0] white_lvl;
  logic                    cal_on;
  logic [CALF_W-1:0]       cal_cnt;
  logic signed [SIG_W-1:0] cal_lo;
  logic signed [SIG_W-1:0] cal_hi;

  task automatic reset_model();
    regs      = '{RST_FRAMES_PER_SYMBOL, RST_CALIBRATION_FRAMES, RST_DEFAULT_THRESHOLD};
    sym_sum   = '0;
    frame_cnt = '0;
    hist      = '0;
    fill      = '0;
    lock_seen = 1'b0;
    black_ok  = 1'b0;
    white_ok  = 1'b0;
    black_lvl = '0;
    white_lvl = RST_WHITE_LEVEL;
    cal_on    = 1'b0;
    cal_cnt   = '0;
    cal_lo    = SIG_MAX;
    cal_hi    = SIG_MIN;
    exp_wr    = '0;
    exp_rd    = '0;
    exp_count = 0;
    fail_count   = 0;
    symbols_seen = 0;
    payload_seen = 0;
  endtask

  // Q16 weighted difference, rounded with ties toward plus infinity
  function automatic logic signed [SIG_W-1:0] luma_diff();
    int db;
    int dg;
    int dr;
    int acc;
    db  = int'(in_if.center_blue)  - int'(in_if.ambient_blue);
    dg  = int'(in_if.center_green) - int'(in_if.ambient_green);
    dr  = int'(in_if.center_red)   - int'(in_if.ambient_red);
    acc = int'(W_BLUE) * db + int'(W_GREEN) * dg + int'(W_RED) * dr;
    acc = (acc + int'(ROUND_HALF)) >>> WGT_FRAC;
    return SIG_W'(acc);
  endfunction

  task automatic predict_frame();
    logic signed [SIG_W-1:0] s;
    logic [CNT_W-1:0]        eff;
    logic                    done;
    logic                    dark;
    longint                  lhs;
    longint                  rhs;
    s    = luma_diff();
    eff  = regs.frames_per_symbol;
    done = 1'b0;
    dark = 1'b0;
    if (eff < EFF_MIN) eff = EFF_MIN;
    if (eff > EFF_MAX) eff = EFF_MAX;

    if (cal_on) begin
      if (s < cal_lo) cal_lo = s;
      if (s > cal_hi) cal_hi = s;
      if (cal_cnt != CAL_CNT_MAX) cal_cnt = cal_cnt + 1'b1;
      if (cal_cnt >= regs.calibration_frames) begin
        cal_on    = 1'b0;
        black_lvl = cal_lo;
        white_lvl = cal_hi;
        black_ok  = 1'b1;
        white_ok  = 1'b1;
      end
    end

    sym_sum   = sym_sum + s;
    frame_cnt = frame_cnt + 1'b1;

    if (frame_cnt >= eff) begin
      if (black_ok && white_ok) begin
        lhs = 2 * longint'(sym_sum);
        rhs = (longint'(black_lvl) + longint'(white_lvl)) * longint'(frame_cnt);
      end else begin
        lhs = longint'(sym_sum);
        rhs = longint'($signed(regs.default_threshold)) * longint'(frame_cnt);
      end
      dark      = !(lhs > rhs);
      done      = 1'b1;
      sym_sum   = '0;
      frame_cnt = '0;
      hist      = {hist[HIST_W-2:0], dark};
      if (fill < SYNC_LEN) fill = fill + 1'b1;
      if (!lock_seen && fill == SYNC_LEN && hist == SYNC_PATTERN) lock_seen = 1'b1;
      symbols_seen++;
      if (lock_seen) payload_seen++;
    end

    case (in_if.action)
      ACT_BLACK: begin
        black_lvl = s;
        black_ok  = 1'b1;
      end
      ACT_WHITE: begin
        white_lvl = s;
        white_ok  = 1'b1;
      end
      ACT_CALIBRATE: begin
        cal_on  = 1'b1;
        cal_cnt = '0;
        cal_lo  = SIG_MAX;
        cal_hi  = SIG_MIN;
      end
      default: ;
    endcase

    if (exp_count == EXP_DEPTH) begin
      fail_count++;
      $display("%0t: more results outstanding than the block can hold, expected at most %0d",
               $time, EXP_DEPTH);
    end else begin
      exp_fifo[exp_wr] = '{s, done, dark, done && lock_seen, lock_seen, cal_on};
      exp_wr = exp_wr + 1'b1;
      exp_count++;
    end
  endtask

  task automatic check_field(string name, logic [SIG_W-1:0] exp_v, logic [SIG_W-1:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, name, $signed(exp_v), $signed(act_v));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (exp_count == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, frame_signal %0d",
                   $time, out_if.frame_signal);
        end else begin
          want = exp_fifo[exp_rd];
          exp_rd = exp_rd + 1'b1;
          exp_count--;
          check_field("frame_signal", want.frame_signal, out_if.frame_signal);
          check_field("symbol_done", SIG_W'(want.symbol_done), SIG_W'(out_if.symbol_done));
          check_field("sliced_bit", SIG_W'(want.sliced_bit), SIG_W'(out_if.sliced_bit));
          check_field("bit_valid", SIG_W'(want.bit_valid), SIG_W'(out_if.bit_valid));
          check_field("sync_locked", SIG_W'(want.sync_locked), SIG_W'(out_if.sync_locked));
          check_field("calibrating", SIG_W'(want.calibrating), SIG_W'(out_if.calibrating));
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_FRAMES_PER_SYMBOL:  regs.frames_per_symbol  = cfg_if.data[CNT_W-1:0];
          REG_CALIBRATION_FRAMES: regs.calibration_frames = cfg_if.data[CALF_W-1:0];
          REG_DEFAULT_THRESHOLD:  regs.default_threshold  = cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) predict_frame();
    end
    pending <= exp_count;
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives frame beats and register writes into the bit slicer: a directed
// pass over extreme colors, thresholds, captures and calibration restarts,
// then randomized phases of sync patterns, random symbols and noise under
// changing register settings and handshake backpressure.
// ----------------------------------------------------------------------------
module testbench;
  import obsd_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int MODE_A_END = 175;
  localparam int MODE_B_END = 350;
  localparam int HOLD_CYCLES = 48;

  typedef struct {
    logic [ACT_W-1:0]   action;
    logic [COLOR_W-1:0] cb, cg, cr, ab, ag, ar;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n;

  int frames_sent   = 0;
  int settings_used = 1;
  int tail_frames   = 0;
  int tx_idle_pct   = 38;
  int rx_idle_pct   = 71;
  int hold_left     = 0;
  int holds_done    = 0;

  int   fail_count;
  int   pending;
  int   symbols_seen;
  int   payload_seen;
  logic lock_seen;

  obsd_in_if  in_if ();
  obsd_out_if out_if ();
  obsd_cfg_if cfg_if ();

  optical_bit_slicer_sync_detect dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  obsd_checker frame_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_if        (in_if),
    .out_if       (out_if),
    .cfg_if       (cfg_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .symbols_seen (symbols_seen),
    .payload_seen (payload_seen),
    .lock_seen    (lock_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("[optical_bit_slicer_sync_detect] ERROR");
    $finish;
  end

  // receiver: random stalls plus two long hold-offs
  always @(posedge clk) begin
    if (hold_left == 0 && holds_done < 2 && frames_sent >= 100 + 260 * holds_done) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic frame_t flat_frame(int c, int a);
    frame_t f;
    f.action = ACT_SAMPLE;
    f.cb = COLOR_W'(c);
    f.cg = COLOR_W'(c);
    f.cr = COLOR_W'(c);
    f.ab = COLOR_W'(a);
    f.ag = COLOR_W'(a);
    f.ar = COLOR_W'(a);
    return f;
  endfunction

  function automatic frame_t level_frame(logic dark);
    frame_t f;
    f.action = ACT_SAMPLE;
    f.cb = COLOR_W'($urandom_range(2400, 4095));
    f.cg = COLOR_W'($urandom_range(2400, 4095));
    f.cr = COLOR_W'($urandom_range(2400, 4095));
    f.ab = COLOR_W'($urandom_range(0, 1600));
    f.ag = COLOR_W'($urandom_range(0, 1600));
    f.ar = COLOR_W'($urandom_range(0, 1600));
    if (dark) begin
      {f.cb, f.ab} = {f.ab, f.cb};
      {f.cg, f.ag} = {f.ag, f.cg};
      {f.cr, f.ar} = {f.ar, f.cr};
    end
    return f;
  endfunction

  function automatic frame_t noise_frame();
    frame_t f;
    f.action = ACT_W'($urandom);
    f.cb = COLOR_W'($urandom);
    f.cg = COLOR_W'($urandom);
    f.cr = COLOR_W'($urandom);
    f.ab = COLOR_W'($urandom);
    f.ag = COLOR_W'($urandom);
    f.ar = COLOR_W'($urandom);
    return f;
  endfunction

  task automatic send_frame(frame_t f);
    if (frames_sent < MODE_A_END) begin
      tx_idle_pct = 38;
      rx_idle_pct = 71;
    end else if (frames_sent < MODE_B_END) begin
      tx_idle_pct = 71;
      rx_idle_pct = 38;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.action        <= f.action;
    in_if.center_blue   <= f.cb;
    in_if.center_green  <= f.cg;
    in_if.center_red    <= f.cr;
    in_if.ambient_blue  <= f.ab;
    in_if.ambient_green <= f.ag;
    in_if.ambient_red   <= f.ar;
    do @(posedge clk); while (!in_if.ready);
    frames_sent++;
  endtask

  // one symbol of eff frames; act rides on one random frame of it
  task automatic send_symbol(logic dark, int eff, logic [ACT_W-1:0] act);
    int     pos;
    frame_t f;
    pos = $urandom_range(eff - 1);
    for (int i = 0; i < eff; i++) begin
      f = ($urandom_range(19) == 0) ? noise_frame() : level_frame(dark);
      f.action = (i == pos) ? act : ACT_SAMPLE;
      send_frame(f);
    end
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= SIG_W'(value);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_phase(int fps, int cal, int thr, int budget);
    int                eff;
    int                start;
    int                pick;
    logic [HIST_W-1:0] pat;
    int                flip;
    wait_idle();
    write_reg(REG_FRAMES_PER_SYMBOL, ($urandom & ~32'h1F) | fps);
    write_reg(REG_CALIBRATION_FRAMES, ($urandom & ~32'hFF) | cal);
    write_reg(REG_DEFAULT_THRESHOLD, thr);
    settings_used++;
    eff = (fps < MIN_SYMBOL_FRAMES) ? MIN_SYMBOL_FRAMES :
          (fps > MAX_SYMBOL_FRAMES) ? MAX_SYMBOL_FRAMES : fps;
    // a partial symbol left over from a longer length closes on the next frame
    if (tail_frames > 0) begin
      send_frame(level_frame(1'b0));
      tail_frames = 0;
    end
    start = frames_sent;
    while (frames_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 40 && eff <= 6) begin
        pat = SYNC_PATTERN;
        if ($urandom_range(9) < 3) begin
          flip = $urandom_range(HIST_W - 1);
          pat[flip] = ~pat[flip];
        end
        for (int i = HIST_W - 1; i >= 0; i--) send_symbol(pat[i], eff, ACT_SAMPLE);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 6)) send_symbol(1'($urandom), eff, ACT_SAMPLE);
      end else if (pick < 85) begin
        repeat (eff) send_frame(noise_frame());
      end else begin
        case ($urandom_range(2))
          0:       send_symbol(1'b1, eff, ACT_BLACK);
          1:       send_symbol(1'b0, eff, ACT_WHITE);
          default: send_symbol(1'($urandom), eff, ACT_CALIBRATE);
        endcase
      end
    end
  endtask

  initial begin
    frame_t f;
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.action        <= ACT_SAMPLE;
    in_if.center_blue   <= '0;
    in_if.center_green  <= '0;
    in_if.center_red    <= '0;
    in_if.ambient_blue  <= '0;
    in_if.ambient_green <= '0;
    in_if.ambient_red   <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_FRAMES_PER_SYMBOL;
    cfg_if.data         <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero, full-scale swings, single channels
    send_frame(flat_frame(0, 0));
    send_frame(flat_frame(4095, 0));
    send_frame(flat_frame(0, 4095));
    send_frame(flat_frame(4095, 4095));
    f = flat_frame(0, 0);
    f.cb = '1;
    send_frame(f);
    f = flat_frame(0, 0);
    f.ag = '1;
    send_frame(f);

    // short symbol below the minimum, highest threshold
    wait_idle();
    write_reg(REG_FRAMES_PER_SYMBOL, 0);
    write_reg(REG_DEFAULT_THRESHOLD, 4080);
    write_reg(REG_UNUSED, 32'h1FFF);
    send_frame(flat_frame(4095, 0));
    send_frame(flat_frame(4095, 0));
    f = flat_frame(4095, 0);
    f.cr = '0;
    send_frame(f);
    send_frame(f);

    // lowest threshold
    wait_idle();
    write_reg(REG_FRAMES_PER_SYMBOL, 1);
    write_reg(REG_DEFAULT_THRESHOLD, -4080);
    send_frame(flat_frame(0, 4095));
    send_frame(flat_frame(0, 4095));
    send_frame(flat_frame(0, 0));
    send_frame(flat_frame(0, 0));

    // captures, then a calibration window restarted while running
    wait_idle();
    write_reg(REG_CALIBRATION_FRAMES, 2);
    f = flat_frame(0, 4095);
    f.action = ACT_BLACK;
    send_frame(f);
    f = flat_frame(4095, 0);
    f.action = ACT_WHITE;
    send_frame(f);
    f = flat_frame(0, 0);
    f.action = ACT_CALIBRATE;
    send_frame(f);
    f = flat_frame(4095, 0);
    f.action = ACT_CALIBRATE;
    send_frame(f);
    send_frame(flat_frame(0, 0));
    send_frame(flat_frame(0, 0));
    settings_used += 3;

    run_phase(4, 20, 320, 70);
    run_phase(2, 0, -4080, 50);
    run_phase(30, 255, 4080, 30);
    run_phase(3, 1, int'($urandom_range(8160)) - 4080, 50);
    run_phase(5, 8, 0, 50);
    repeat (4) send_frame(level_frame(1'b0));
    tail_frames = 4;
    run_phase(2, $urandom_range(255), int'($urandom_range(8160)) - 4080, 50);
    run_phase(31, $urandom_range(255), int'($urandom_range(8160)) - 4080, 30);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Run covered %0d frames under %0d register settings: %0d symbols, %0d payload bits.",
             frames_sent, settings_used, symbols_seen, payload_seen);
    $display("Sync lock %s; %0d long receiver hold-offs.",
             lock_seen ? "was reached" : "was not reached", holds_done);
    if (fail_count == 0) begin
      $display("[optical_bit_slicer_sync_detect] OK");
    end else begin
      $display("[optical_bit_slicer_sync_detect] ERROR");
    end
    $finish;
  end

endmodule
